/* hdl/gga_pkg.sv */
// Package for the gated greedy track association block.
// Shared types, codes and helper functions; no dependencies.
package gga_pkg;

  // Default table sizes
  localparam int MAX_TRACKS_DEF       = 8;
  localparam int MAX_OBSERVATIONS_DEF = 8;

  // Request op codes
  localparam logic [1:0] OP_LOAD_TRACK = 2'd0;
  localparam logic [1:0] OP_LOAD_OBS   = 2'd1;
  localparam logic [1:0] OP_RUN        = 2'd2;

  // Result outcome codes
  localparam logic [1:0] OUTCOME_ASSOC = 2'd0;
  localparam logic [1:0] OUTCOME_SPAWN = 2'd1;
  localparam logic [1:0] OUTCOME_DROP  = 2'd2;

  // Object kinds
  localparam logic [1:0] KIND_LASER  = 2'd0;
  localparam logic [1:0] KIND_BALL   = 2'd1;
  localparam logic [1:0] KIND_MARKER = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_GATE         = 2'd0;
  localparam logic [1:0] REG_LIMIT_LASER  = 2'd1;
  localparam logic [1:0] REG_LIMIT_BALL   = 2'd2;
  localparam logic [1:0] REG_LIMIT_MARKER = 2'd3;

  // Register reset values
  localparam logic [14:0] GATE_RST         = 15'd320;
  localparam logic [3:0]  LIMIT_LASER_RST  = 4'd1;
  localparam logic [3:0]  LIMIT_BALL_RST   = 4'd1;
  localparam logic [3:0]  LIMIT_MARKER_RST = 4'd8;

  typedef struct packed {
    logic [14:0] gate_distance;
    logic [3:0]  limit_laser;
    logic [3:0]  limit_ball;
    logic [3:0]  limit_marker;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               accepting;
  } cmd_t;

  // Live-track limit for a kind; kind 3 has none allowed
  function automatic logic [3:0] kind_limit(input cfg_t c, input logic [1:0] k);
    logic [3:0] lim;
    unique case (k)
      KIND_LASER:  lim = c.limit_laser;
      KIND_BALL:   lim = c.limit_ball;
      KIND_MARKER: lim = c.limit_marker;
      default:     lim = 4'd0;
    endcase
    return lim;
  endfunction

endpackage

/* hdl/gga_if.sv */
// Stream channel interfaces for the association block.
// Depends on nothing; payload widths are fixed by the item formats.
interface gga_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [1:0]         kind;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               accepting;

  modport source (output valid, op, kind, pos_x, pos_y, accepting, input ready);
  modport sink   (input valid, op, kind, pos_x, pos_y, accepting, output ready);
endinterface

interface gga_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] obs_index;
  logic [1:0] outcome;
  logic [2:0] trk_slot;
  logic       last;

  modport source (output valid, obs_index, outcome, trk_slot, last, input ready);
  modport sink   (input valid, obs_index, outcome, trk_slot, last, output ready);
endinterface

/* hdl/gga_regs.sv */
// APB-style configuration registers: gate radius and per-kind limits.
// Depends on gga_pkg.
module gga_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [3:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready,
  output gga_pkg::cfg_t cfg
);
  import gga_pkg::*;

  cfg_t       cfg_r;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gate_distance <= GATE_RST;
      cfg_r.limit_laser   <= LIMIT_LASER_RST;
      cfg_r.limit_ball    <= LIMIT_BALL_RST;
      cfg_r.limit_marker  <= LIMIT_MARKER_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GATE:         cfg_r.gate_distance <= cfg_pwdata[14:0];
        REG_LIMIT_LASER:  cfg_r.limit_laser   <= cfg_pwdata[3:0];
        REG_LIMIT_BALL:   cfg_r.limit_ball    <= cfg_pwdata[3:0];
        REG_LIMIT_MARKER: cfg_r.limit_marker  <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_GATE:         cfg_prdata = {17'd0, cfg_r.gate_distance};
      REG_LIMIT_LASER:  cfg_prdata = {28'd0, cfg_r.limit_laser};
      REG_LIMIT_BALL:   cfg_prdata = {28'd0, cfg_r.limit_ball};
      REG_LIMIT_MARKER: cfg_prdata = {28'd0, cfg_r.limit_marker};
      default:          cfg_prdata = 32'd0;
    endcase
  end
endmodule

/* hdl/gga_front.sv */
// Front end: accepts requests, drops unknown ops, queues the rest.
// Depends on gga_pkg and gga_in_if.
module gga_front (
  input  logic           clk,
  input  logic           rst_n,
  gga_in_if.sink         in_chan,
  output gga_pkg::cmd_t  q_cmd,
  output logic           q_valid,
  input  logic           q_pop
);
  import gga_pkg::*;

  localparam int QDEPTH = 2;

  cmd_t       q_mem_r [QDEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;
  cmd_t       in_cmd;

  assign in_cmd = '{op: in_chan.op, kind: in_chan.kind, pos_x: in_chan.pos_x,
                    pos_y: in_chan.pos_y, accepting: in_chan.accepting};

  assign in_chan.ready = (count_r != 2'(QDEPTH));
  // Op 3 is taken and discarded here
  assign push    = in_chan.valid && in_chan.ready &&
                   (in_chan.op == OP_LOAD_TRACK || in_chan.op == OP_LOAD_OBS ||
                    in_chan.op == OP_RUN);
  assign q_valid = (count_r != 2'd0);
  assign pop     = q_pop && q_valid;
  assign q_cmd   = q_mem_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= in_cmd;
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end
endmodule

/* hdl/gga_engine.sv */
// Back end: track/observation tables, greedy nearest-pair search,
// spawn decisions and result output. Depends on gga_pkg and gga_out_if.
module gga_engine #(
  parameter int MAX_TRACKS       = gga_pkg::MAX_TRACKS_DEF,
  parameter int MAX_OBSERVATIONS = gga_pkg::MAX_OBSERVATIONS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  gga_pkg::cfg_t cfg,
  input  gga_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  gga_out_if.source     out_chan
);
  import gga_pkg::*;

  localparam int TW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int OW  = (MAX_OBSERVATIONS > 1) ? $clog2(MAX_OBSERVATIONS) : 1;
  localparam int TCW = $clog2(MAX_TRACKS + 1);
  localparam int OCW = $clog2(MAX_OBSERVATIONS + 1);
  localparam int LCW = (TCW > 4) ? TCW : 4;
  localparam int SQW = 33;
  localparam int DW  = 34;
  localparam int GW  = 30;

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_SPAWN, ST_EMIT} state_t;

  state_t state_r;

  // Tables
  logic signed [15:0] trk_x_r    [MAX_TRACKS];
  logic signed [15:0] trk_y_r    [MAX_TRACKS];
  logic [1:0]         trk_kind_r [MAX_TRACKS];
  logic [MAX_TRACKS-1:0] trk_live_r;
  logic [MAX_TRACKS-1:0] trk_taken_r;
  logic [TCW-1:0]     trk_total_r;
  logic signed [15:0] obs_x_r    [MAX_OBSERVATIONS];
  logic signed [15:0] obs_y_r    [MAX_OBSERVATIONS];
  logic [1:0]         obs_kind_r [MAX_OBSERVATIONS];
  logic [MAX_OBSERVATIONS-1:0] obs_taken_r;
  logic [OCW-1:0]     obs_total_r;
  logic [1:0]         outcome_r  [MAX_OBSERVATIONS];
  logic [TW-1:0]      slot_r     [MAX_OBSERVATIONS];
  logic [TCW-1:0]     live_cnt_r [4];
  logic [TCW-1:0]     size_r;
  logic [GW-1:0]      gate_sq_r;

  // Scan counters and pipeline
  logic [TW-1:0]      t_r;
  logic [OW-1:0]      o_r;
  logic               s1_v_r, s2_v_r;
  logic [TW-1:0]      s1_t_r, s2_t_r;
  logic [OW-1:0]      s1_o_r, s2_o_r;
  logic signed [16:0] s1_dx_r, s1_dy_r;
  logic [SQW-1:0]     s2_sqx_r, s2_sqy_r;
  logic               found_r;
  logic [DW-1:0]      best_r;
  logic [TW-1:0]      bt_r;
  logic [OW-1:0]      bo_r;

  // Output register
  logic               out_valid_r;
  logic [2:0]         out_obs_r;
  logic [1:0]         out_outcome_r;
  logic [2:0]         out_track_r;
  logic               out_last_r;

  logic               elig;
  logic               o_wrap, t_wrap;
  logic [DW-1:0]      pair_dist;
  logic               hit;
  logic               found_clr;
  logic signed [33:0] prod_x, prod_y;
  logic [1:0]         sp_kind;
  logic               sp_ok;
  logic               out_load;
  logic [TW-1:0]      trk_wr_idx;
  logic [OW-1:0]      obs_wr_idx;

  assign trk_wr_idx = trk_total_r[TW-1:0];
  assign obs_wr_idx = obs_total_r[OW-1:0];

  // Pair eligibility at the issue point
  assign elig = trk_live_r[t_r] && !trk_taken_r[t_r] && !obs_taken_r[o_r] &&
                (trk_kind_r[t_r] == obs_kind_r[o_r]);
  assign o_wrap = (OCW'(o_r) + OCW'(1)) == obs_total_r;
  assign t_wrap = (TCW'(t_r) + TCW'(1)) == trk_total_r;

  // Squares of the coordinate differences
  assign prod_x = s1_dx_r * s1_dx_r;
  assign prod_y = s1_dy_r * s1_dy_r;

  // Distance, gate and running-minimum compare
  assign pair_dist = {1'b0, s2_sqx_r} + {1'b0, s2_sqy_r};
  assign hit  = s2_v_r && (pair_dist < DW'(gate_sq_r)) &&
                (!found_r || pair_dist < best_r);
  // pass winner is forgotten when idle and once the pass is committed
  assign found_clr = (state_r == ST_IDLE) ||
                     ((state_r == ST_DRAIN) && !s1_v_r && !s2_v_r);

  // Spawn test for the current observation
  assign sp_kind = obs_kind_r[o_r];
  assign sp_ok   = !obs_taken_r[o_r] && (size_r < TCW'(MAX_TRACKS)) &&
                   (LCW'(live_cnt_r[sp_kind]) < LCW'(kind_limit(cfg, sp_kind)));

  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_chan.ready);
  assign cmd_pop  = (state_r == ST_IDLE) && cmd_valid;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.obs_index = out_obs_r;
  assign out_chan.outcome   = out_outcome_r;
  assign out_chan.trk_slot  = out_track_r;
  assign out_chan.last      = out_last_r;

  // Sequencer, tables and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      trk_total_r <= '0;
      obs_total_r <= '0;
      trk_taken_r <= '0;
      obs_taken_r <= '0;
      for (int k = 0; k < 4; k++) live_cnt_r[k] <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // pipeline advances every cycle
      s1_v_r   <= (state_r == ST_SCAN) && elig;
      s2_v_r   <= s1_v_r;
      s2_t_r   <= s1_t_r;
      s2_o_r   <= s1_o_r;
      s2_sqx_r <= prod_x[SQW-1:0];
      s2_sqy_r <= prod_y[SQW-1:0];
      if (hit) begin
        found_r <= 1'b1;
        best_r  <= pair_dist;
        bt_r    <= s2_t_r;
        bo_r    <= s2_o_r;
      end else if (found_clr) begin
        found_r <= 1'b0;
      end
      out_valid_r <= out_load || (out_valid_r && !out_chan.ready);

      unique case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            priority case (cmd.op)
              OP_LOAD_TRACK: begin
                if (trk_total_r < TCW'(MAX_TRACKS)) begin
                  trk_x_r[trk_wr_idx]    <= cmd.pos_x;
                  trk_y_r[trk_wr_idx]    <= cmd.pos_y;
                  trk_kind_r[trk_wr_idx] <= cmd.kind;
                  trk_live_r[trk_wr_idx] <= cmd.accepting;
                  trk_total_r            <= trk_total_r + TCW'(1);
                  if (cmd.accepting)
                    live_cnt_r[cmd.kind] <= live_cnt_r[cmd.kind] + TCW'(1);
                end
              end
              OP_LOAD_OBS: begin
                if (obs_total_r < OCW'(MAX_OBSERVATIONS)) begin
                  obs_x_r[obs_wr_idx]    <= cmd.pos_x;
                  obs_y_r[obs_wr_idx]    <= cmd.pos_y;
                  obs_kind_r[obs_wr_idx] <= cmd.kind;
                  obs_total_r            <= obs_total_r + OCW'(1);
                end
              end
              OP_RUN: begin
                gate_sq_r <= GW'({15'd0, cfg.gate_distance} * {15'd0, cfg.gate_distance});
                for (int k = 0; k < MAX_OBSERVATIONS; k++) begin
                  outcome_r[k] <= OUTCOME_DROP;
                  slot_r[k]    <= '0;
                end
                size_r  <= trk_total_r;
                t_r     <= '0;
                o_r     <= '0;
                if (trk_total_r != '0 && obs_total_r != '0) state_r <= ST_SCAN;
                else state_r <= ST_SPAWN;
              end
              default: ;
            endcase
          end
        end

        // one pair per cycle, track-major order
        ST_SCAN: begin
          s1_t_r  <= t_r;
          s1_o_r  <= o_r;
          s1_dx_r <= 17'(obs_x_r[o_r]) - 17'(trk_x_r[t_r]);
          s1_dy_r <= 17'(obs_y_r[o_r]) - 17'(trk_y_r[t_r]);
          if (o_wrap) begin
            o_r <= '0;
            if (t_wrap) state_r <= ST_DRAIN;
            else t_r <= t_r + TW'(1);
          end else begin
            o_r <= o_r + OW'(1);
          end
        end

        // let the pipeline empty, then commit the pass winner
        ST_DRAIN: begin
          if (!s1_v_r && !s2_v_r) begin
            o_r <= '0;
            if (found_r) begin
              trk_taken_r[bt_r] <= 1'b1;
              obs_taken_r[bo_r] <= 1'b1;
              outcome_r[bo_r]   <= OUTCOME_ASSOC;
              slot_r[bo_r]      <= bt_r;
              t_r               <= '0;
              state_r           <= ST_SCAN;
            end else begin
              state_r <= ST_SPAWN;
            end
          end
        end

        ST_SPAWN: begin
          if (obs_total_r == '0) begin
            // nothing to report: clear and return
            trk_total_r <= '0;
            trk_taken_r <= '0;
            obs_taken_r <= '0;
            for (int k = 0; k < 4; k++) live_cnt_r[k] <= '0;
            state_r <= ST_IDLE;
          end else begin
            if (sp_ok) begin
              outcome_r[o_r]      <= OUTCOME_SPAWN;
              slot_r[o_r]         <= size_r[TW-1:0];
              size_r              <= size_r + TCW'(1);
              live_cnt_r[sp_kind] <= live_cnt_r[sp_kind] + TCW'(1);
            end
            if (o_wrap) begin
              o_r     <= '0;
              state_r <= ST_EMIT;
            end else begin
              o_r <= o_r + OW'(1);
            end
          end
        end

        ST_EMIT: begin
          if (out_load) begin
            out_obs_r     <= 3'(o_r);
            out_outcome_r <= outcome_r[o_r];
            out_track_r   <= 3'(slot_r[o_r]);
            out_last_r    <= o_wrap;
            if (o_wrap) begin
              trk_total_r <= '0;
              obs_total_r <= '0;
              trk_taken_r <= '0;
              obs_taken_r <= '0;
              for (int k = 0; k < 4; k++) live_cnt_r[k] <= '0;
              state_r <= ST_IDLE;
            end else begin
              o_r <= o_r + OW'(1);
            end
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

/* hdl/gated_greedy_track_association.sv */
// Top level of the gated greedy track association block.
// Depends on gga_pkg, gga_if, gga_regs, gga_front and gga_engine.
//
// Usage:
//   in_chan carries requests: op 0 loads a track, op 1 loads an observation,
//   op 2 runs the association and clears both lists; op 3 is discarded.
//   Loads beyond the table sizes are ignored.
//   out_chan carries one result per observation after a run, in observation
//   order, with last set on the final one. A run with no observations gives
//   no results.
//   The cfg_ APB port sets the gate radius and per-kind live-track limits;
//   write it only while the block is idle.
// Timing:
//   Each pass of the search walks every pair of the T tracks and O
//   observations through a three-stage distance pipeline, one pair per cycle;
//   a run with M associations makes M + 1 passes.
//   A two-entry request queue lets loads arrive while a run is in progress.
// Reset clears the lists, the counts and the output register; registers
// return to their reset values. A stalled receiver holds the output
// register and stops the run at its result stage; the queue then fills.
module gated_greedy_track_association #(
  parameter int MAX_TRACKS       = gga_pkg::MAX_TRACKS_DEF,
  parameter int MAX_OBSERVATIONS = gga_pkg::MAX_OBSERVATIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gga_in_if.sink      in_chan,
  gga_out_if.source   out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import gga_pkg::*;

  cfg_t cfg;
  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;

  gga_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg
  );

  gga_front u_front (
    .clk, .rst_n, .in_chan, .q_cmd, .q_valid, .q_pop
  );

  gga_engine #(
    .MAX_TRACKS       (MAX_TRACKS),
    .MAX_OBSERVATIONS (MAX_OBSERVATIONS)
  ) u_engine (
    .clk, .rst_n, .cfg, .cmd(q_cmd), .cmd_valid(q_valid), .cmd_pop(q_pop),
    .out_chan
  );
endmodule

/* hdl/gga_checker.sv */
// Port-level checks for the association block, bound to the top level.
// Depends on gga_pkg.
module gga_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] outcome,
  input logic [2:0] trk_slot,
  input logic       cfg_pready
);
  import gga_pkg::*;

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Dropped observations report track slot zero
  a_drop_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && outcome == OUTCOME_DROP |-> trk_slot == 3'd0)
    else $error("dropped result with nonzero track slot");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Configuration port never waits
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("cfg_pready low");
endmodule

bind gated_greedy_track_association gga_checker u_gga_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .outcome     (out_chan.outcome),
  .trk_slot    (out_chan.trk_slot),
  .cfg_pready  (cfg_pready)
);

/* bench/gga_tb_pkg.sv */
// Scoreboard for the gated greedy track association testbench.
// Depends on gga_pkg; predicts run results from the loaded requests.
`timescale 1ns / 100ps
package gga_tb_pkg;
  import gga_pkg::*;

  typedef struct packed {
    logic [2:0] obs_index;
    logic [1:0] outcome;
    logic [2:0] trk_slot;
    logic       last;
  } assoc_res_t;

  class assoc_scoreboard;
    cfg_t               cfg;
    logic signed [15:0] trk_x[8], trk_y[8], obs_x[8], obs_y[8];
    logic [1:0]         trk_kind[8], obs_kind[8];
    bit                 trk_live[8];
    int                 n_trk, n_obs;
    assoc_res_t         pending[$];
    int                 errors;

    function new();
      cfg = '{GATE_RST, LIMIT_LASER_RST, LIMIT_BALL_RST, LIMIT_MARKER_RST};
      n_trk = 0;
      n_obs = 0;
      errors = 0;
    endfunction

    function logic [3:0] limit_of(logic [1:0] k);
      case (k)
        KIND_LASER:  return cfg.limit_laser;
        KIND_BALL:   return cfg.limit_ball;
        KIND_MARKER: return cfg.limit_marker;
        default:     return 4'd0;
      endcase
    endfunction

    // Note one accepted request; a run queues its results
    function void note_request(cmd_t c);
      longint gsq, d, best, dx, dy;
      bit t_used[8], o_used[8];
      logic [1:0] outc[8];
      int slot[8], bt, bo, size, live;
      bit found;
      assoc_res_t res;
      if (c.op == OP_LOAD_TRACK) begin
        if (n_trk < 8) begin
          trk_x[n_trk] = c.pos_x; trk_y[n_trk] = c.pos_y;
          trk_kind[n_trk] = c.kind; trk_live[n_trk] = c.accepting;
          n_trk++;
        end
        return;
      end
      if (c.op == OP_LOAD_OBS) begin
        if (n_obs < 8) begin
          obs_x[n_obs] = c.pos_x; obs_y[n_obs] = c.pos_y;
          obs_kind[n_obs] = c.kind;
          n_obs++;
        end
        return;
      end
      if (c.op != OP_RUN) return;
      gsq = longint'(cfg.gate_distance) * longint'(cfg.gate_distance);
      for (int i = 0; i < 8; i++) begin
        t_used[i] = 0; o_used[i] = 0; outc[i] = OUTCOME_DROP; slot[i] = 0;
      end
      // greedy global nearest pair, ties to lower track then observation
      do begin
        found = 0; best = 0; bt = 0; bo = 0;
        for (int t = 0; t < n_trk; t++) begin
          if (!trk_live[t] || t_used[t]) continue;
          for (int o = 0; o < n_obs; o++) begin
            if (o_used[o] || obs_kind[o] != trk_kind[t]) continue;
            dx = longint'(obs_x[o]) - longint'(trk_x[t]);
            dy = longint'(obs_y[o]) - longint'(trk_y[t]);
            d = dx * dx + dy * dy;
            if (d >= gsq) continue;
            if (!found || d < best) begin
              found = 1; best = d; bt = t; bo = o;
            end
          end
        end
        if (found) begin
          t_used[bt] = 1; o_used[bo] = 1; outc[bo] = OUTCOME_ASSOC; slot[bo] = bt;
        end
      end while (found);
      // spawning of leftovers
      size = n_trk;
      for (int o = 0; o < n_obs; o++) begin
        if (o_used[o] || size >= 8) continue;
        live = 0;
        for (int t = 0; t < size; t++)
          if (trk_kind[t] == obs_kind[o] && trk_live[t]) live++;
        if (live >= limit_of(obs_kind[o])) continue;
        trk_x[size] = obs_x[o]; trk_y[size] = obs_y[o];
        trk_kind[size] = obs_kind[o]; trk_live[size] = 1;
        outc[o] = OUTCOME_SPAWN; slot[o] = size;
        size++;
      end
      for (int o = 0; o < n_obs; o++) begin
        res = '{3'(o), outc[o], 3'(slot[o]), o + 1 == n_obs};
        pending.insert(pending.size(), res);
      end
      n_trk = 0;
      n_obs = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(assoc_res_t r);
      assoc_res_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %p", r));
        return;
      end
      e = pending.pop_front();
      if (r.obs_index != e.obs_index)
        report($sformatf("obs_index %0d, want %0d", r.obs_index, e.obs_index));
      if (r.outcome != e.outcome)
        report($sformatf("obs %0d outcome %0d, want %0d", e.obs_index, r.outcome,
                         e.outcome));
      if (r.trk_slot != e.trk_slot)
        report($sformatf("obs %0d track slot %0d, want %0d", e.obs_index,
                         r.trk_slot, e.trk_slot));
      if (r.last != e.last)
        report($sformatf("obs %0d last %0b, want %0b", e.obs_index, r.last, e.last));
    endfunction
  endclass
endpackage

/* bench/gated_greedy_track_association_tb.sv */
// Testbench top for gated_greedy_track_association.
// Depends on gga_pkg, gga_if, gga_tb_pkg and the block's RTL.
`timescale 1ns / 100ps
module gated_greedy_track_association_tb;
  import gga_pkg::*;
  import gga_tb_pkg::*;

  // op and kind values with no meaning of their own
  localparam logic [1:0] OP_SPARE   = 2'd3;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;
  int          send_idle_pct, recv_stall_pct;
  bit          stim_done;

  gga_in_if  in_chan();
  gga_out_if out_chan();
  assoc_scoreboard sb;

  gated_greedy_track_association dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Result side: random stall, check at rising edge
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result('{out_chan.obs_index, out_chan.outcome, out_chan.trk_slot,
                        out_chan.last});
  end

  // Send one request, with random idling before it
  task automatic send_request(cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.op        <= c.op;
    in_chan.kind      <= c.kind;
    in_chan.pos_x     <= c.pos_x;
    in_chan.pos_y     <= c.pos_y;
    in_chan.accepting <= c.accepting;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_request(c);
    @(negedge clk);
  endtask

  // Wait for all results, then let the block settle before a register write
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_GATE:         sb.cfg.gate_distance = val[14:0];
      REG_LIMIT_LASER:  sb.cfg.limit_laser   = val[3:0];
      REG_LIMIT_BALL:   sb.cfg.limit_ball    = val[3:0];
      REG_LIMIT_MARKER: sb.cfg.limit_marker  = val[3:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(int gate, int ll, int lb, int lm);
    drain();
    write_reg(REG_GATE, gate);
    write_reg(REG_LIMIT_LASER, ll);
    write_reg(REG_LIMIT_BALL, lb);
    write_reg(REG_LIMIT_MARKER, lm);
  endtask

  function automatic cmd_t mk(logic [1:0] op, logic [1:0] k, int x, int y, bit a);
    return '{op, k, 16'(x), 16'(y), a};
  endfunction

  // One frame: tracks, observations near them, then a run
  task automatic random_frame(output int n_sent);
    int nt, no, cx, cy, spread;
    logic signed [15:0] px[16], py[16];
    cmd_t c;
    nt = $urandom_range(9);
    no = $urandom_range(9);
    spread = ($urandom_range(3) == 0) ? 65535 : $urandom_range(1, 800);
    cx = $urandom_range(65535) - 32768;
    cy = $urandom_range(65535) - 32768;
    n_sent = 0;
    for (int i = 0; i < nt; i++) begin
      px[i] = 16'(cx + $urandom_range(spread) - spread / 2);
      py[i] = 16'(cy + $urandom_range(spread) - spread / 2);
      send_request(mk(OP_LOAD_TRACK, 2'($urandom_range(3) == 0 ? $urandom_range(3) :
                      $urandom_range(2)), px[i], py[i], $urandom_range(4) != 0));
      n_sent++;
    end
    for (int i = 0; i < no; i++) begin
      c = mk(OP_LOAD_OBS, 2'($urandom_range(2)), cx + $urandom_range(spread) - spread / 2,
             cy + $urandom_range(spread) - spread / 2, 1'($urandom_range(1)));
      if (nt > 0 && $urandom_range(1)) begin
        c.pos_x = px[i % nt] + 16'($urandom_range(40) - 20);
        c.pos_y = py[i % nt] + 16'($urandom_range(40) - 20);
      end
      if ($urandom_range(19) == 0) c.kind = KIND_SPARE;
      send_request(c);
      n_sent++;
    end
    if ($urandom_range(19) == 0) begin
      send_request(mk(OP_SPARE, 2'($urandom_range(3)), $urandom_range(65535),
                      $urandom_range(65535), 1'($urandom_range(1))));
    end
    send_request(mk(OP_RUN, 2'($urandom_range(3)), $urandom_range(65535),
                    $urandom_range(65535), 1'($urandom_range(1))));
    n_sent++;
  endtask

  initial begin
    int sent, n;
    sb = new();
    rst_n = 1'b0;
    stim_done = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    in_chan.valid = 1'b0; in_chan.op = OP_LOAD_TRACK; in_chan.kind = KIND_LASER;
    in_chan.pos_x = '0; in_chan.pos_y = '0; in_chan.accepting = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: default limits, extremes, tie, kind 3, overflow, empty run
    send_request(mk(OP_RUN, KIND_LASER, 0, 0, 0));
    send_request(mk(OP_LOAD_TRACK, KIND_BALL, 100, 100, 1));
    send_request(mk(OP_LOAD_TRACK, KIND_BALL, 100, 100, 1));
    send_request(mk(OP_LOAD_TRACK, KIND_SPARE, -32768, 32767, 1));
    send_request(mk(OP_LOAD_TRACK, KIND_LASER, 32767, -32768, 0));
    send_request(mk(OP_LOAD_OBS, KIND_BALL, 110, 100, 0));
    send_request(mk(OP_LOAD_OBS, KIND_BALL, 100, 110, 1));
    send_request(mk(OP_LOAD_OBS, KIND_SPARE, -32768, 32767, 0));
    send_request(mk(OP_LOAD_OBS, KIND_LASER, 32767, -32768, 0));
    send_request(mk(OP_LOAD_OBS, KIND_MARKER, 0, 0, 0));
    send_request(mk(OP_SPARE, KIND_SPARE, -1, -1, 1));
    send_request(mk(OP_RUN, KIND_LASER, 0, 0, 0));
    set_config(32767, 8, 0, 0);
    for (int i = 0; i < 9; i++) send_request(mk(OP_LOAD_TRACK, KIND_LASER, i, -i, 1));
    for (int i = 0; i < 9; i++) send_request(mk(OP_LOAD_OBS, KIND_LASER, -i, i, 0));
    send_request(mk(OP_RUN, KIND_LASER, 0, 0, 0));
    sent = 31;

    // Random phases across settings and idling modes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      case (ph)
        0: set_config(0, 0, 0, 0);
        1: set_config(320, 1, 1, 8);
        2: set_config(32767, 8, 8, 8);
        3: set_config(1, 15, 15, 15);
        default: set_config($urandom_range(32767), $urandom_range(8),
                            $urandom_range(8), $urandom_range(8));
      endcase
      for (int k = 0; k < 45 / 8 + 3 && sent < 42 + (ph + 1) * 40; k++) begin
        random_frame(n);
        sent += n;
      end
    end
    drain();
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
